>>> hw/rtl/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg: shared types and constants of the sound level meter
// Field widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned MAX_WINDOW  = 4096;

  localparam int unsigned WIN_W       = 13;
  localparam int unsigned THR_W       = 23;
  localparam int unsigned MEAN_W      = 23;
  localparam int unsigned INT_W       = 3;
  localparam int unsigned NUM_LEVELS  = 4;
  localparam int unsigned LVL_IDX_W   = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 23;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 3'd0,
    REG_LEVEL_ONE     = 3'd1,
    REG_LEVEL_TWO     = 3'd2,
    REG_LEVEL_THREE   = 3'd3,
    REG_LEVEL_FOUR    = 3'd4
  } reg_idx_e;

  localparam logic [WIN_W-1:0] WINDOW_RST      = 13'd1024;
  localparam logic [THR_W-1:0] LEVEL_ONE_RST   = 23'd62;
  localparam logic [THR_W-1:0] LEVEL_TWO_RST   = 23'd617;
  localparam logic [THR_W-1:0] LEVEL_THREE_RST = 23'd6163;
  localparam logic [THR_W-1:0] LEVEL_FOUR_RST  = 23'd61623;

  typedef struct packed {
    logic [WIN_W-1:0]                       window_length;
    logic [NUM_LEVELS-1:0][THR_W-1:0]       level_threshold;
  } cfg_t;

  typedef struct packed {
    logic [INT_W-1:0]  intensity;
    logic              silent;
    logic [MEAN_W-1:0] mean_square;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_SQUARE   = 3'd1,
    ST_ACCUM    = 3'd2,
    ST_DIVIDE   = 3'd3,
    ST_CLASSIFY = 3'd4,
    ST_DONE     = 3'd5
  } state_e;

endpackage

>>> hw/rtl/slm_sub.sv
// ----------------------------------------------------------------------------
// slm_sub: shared trial subtractor
// Gives a - b and whether a >= b; used for divide steps and threshold checks.
// ----------------------------------------------------------------------------
module slm_sub #(
  parameter int unsigned Width = 35
) (
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  output logic [Width-1:0] diff_o,
  output logic             ge_o
);

  logic [Width:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  // no borrow out means a >= b
  assign ge_o   = ~full[Width];
  assign diff_o = full[Width-1:0];

endmodule

>>> hw/rtl/slm_engine.sv
// ----------------------------------------------------------------------------
// slm_engine: accumulate and reduce sequencer
// Squares and sums centred samples; at window end divides bit by bit and
// classifies the mean against the thresholds with the shared subtractor.
// ----------------------------------------------------------------------------
module slm_engine #(
  parameter int unsigned SampleBits = slm_pkg::SAMPLE_BITS,
  parameter int unsigned MaxWindow  = slm_pkg::MAX_WINDOW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slm_pkg::cfg_t         cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SampleBits-1:0] sample_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output slm_pkg::res_t         res_o
);

  localparam int unsigned CntW  = $clog2(MaxWindow + 1);
  localparam int unsigned SqW   = 2 * SampleBits - 1;
  localparam int unsigned SumW  = CntW + 2 * SampleBits - 2;
  localparam int unsigned StepW = $clog2(SumW);
  localparam int unsigned CmpW  = (CntW > slm_pkg::WIN_W) ? CntW : slm_pkg::WIN_W;
  localparam int unsigned AluW  = (SumW > slm_pkg::THR_W) ? SumW : slm_pkg::THR_W;

  localparam logic [SampleBits-1:0]    Half    = {1'b1, {(SampleBits-1){1'b0}}};
  localparam logic [CmpW-1:0]          MaxWin  = CmpW'(MaxWindow);
  localparam logic [slm_pkg::INT_W-1:0] LastLvl = slm_pkg::INT_W'(slm_pkg::NUM_LEVELS - 1);

  slm_pkg::state_e state_q, state_d;

  logic [SampleBits-1:0]       mag, mag_q;
  logic [2*SampleBits-1:0]     prod;
  logic [SqW-1:0]              sq_q;
  logic [SumW-1:0]             sum_q;
  logic [CntW-1:0]             cnt_q, cnt_inc;
  logic [CntW-1:0]             rem_q;
  logic [StepW-1:0]            step_q;
  logic [slm_pkg::INT_W-1:0]   lvl_q;
  logic                        silent_q;
  logic [CmpW-1:0]             win_ext, eff_win;
  logic                        close;
  logic [CntW:0]               trial;
  logic [AluW-1:0]             alu_a, alu_b, alu_diff;
  logic                        alu_ge;

  // centre on mid-scale and take the magnitude
  assign mag = sample_i[SampleBits-1] ? {1'b0, sample_i[SampleBits-2:0]} : Half - sample_i;
  assign prod = mag_q * mag_q;

  assign cnt_inc = cnt_q + CntW'(1);
  assign win_ext = CmpW'(cfg_i.window_length);

  always_comb begin
    eff_win = win_ext;
    if (win_ext == '0) begin
      eff_win = CmpW'(1);
    end else if (win_ext > MaxWin) begin
      eff_win = MaxWin;
    end
  end

  assign close = CmpW'(cnt_inc) >= eff_win;
  assign trial = {rem_q, sum_q[SumW-1]};

  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_q)
      slm_pkg::ST_DIVIDE: begin
        alu_a = AluW'(trial);
        alu_b = AluW'(cnt_q);
      end
      slm_pkg::ST_CLASSIFY: begin
        alu_a = AluW'(sum_q);
        alu_b = AluW'(cfg_i.level_threshold[lvl_q[slm_pkg::LVL_IDX_W-1:0]]);
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  slm_sub #(
    .Width(AluW)
  ) u_sub (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .diff_o(alu_diff),
    .ge_o  (alu_ge)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      slm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = slm_pkg::ST_SQUARE;
        end
      end
      slm_pkg::ST_SQUARE: begin
        state_d = slm_pkg::ST_ACCUM;
      end
      slm_pkg::ST_ACCUM: begin
        state_d = close ? slm_pkg::ST_DIVIDE : slm_pkg::ST_IDLE;
      end
      slm_pkg::ST_DIVIDE: begin
        if (step_q == '0) begin
          state_d = slm_pkg::ST_CLASSIFY;
        end
      end
      slm_pkg::ST_CLASSIFY: begin
        if (!alu_ge || lvl_q == LastLvl) begin
          state_d = slm_pkg::ST_DONE;
        end
      end
      slm_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = slm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = slm_pkg::ST_IDLE;
      end
    endcase
  end

  // window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      step_q <= '0;
      lvl_q  <= '0;
    end else begin
      case (state_q)
        slm_pkg::ST_ACCUM: begin
          sum_q  <= sum_q + SumW'(sq_q);
          cnt_q  <= cnt_inc;
          step_q <= StepW'(SumW - 1);
        end
        slm_pkg::ST_DIVIDE: begin
          // dividend shifts out at the top, quotient bits shift in below
          sum_q  <= {sum_q[SumW-2:0], alu_ge};
          step_q <= step_q - StepW'(1);
          lvl_q  <= '0;
        end
        slm_pkg::ST_CLASSIFY: begin
          if (alu_ge) begin
            lvl_q <= lvl_q + slm_pkg::INT_W'(1);
          end
        end
        slm_pkg::ST_DONE: begin
          if (res_ready_i) begin
            sum_q <= '0;
            cnt_q <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == slm_pkg::ST_IDLE && in_valid_i) begin
      mag_q <= mag;
    end
    if (state_q == slm_pkg::ST_SQUARE) begin
      sq_q <= prod[SqW-1:0];
    end
    if (state_q == slm_pkg::ST_ACCUM) begin
      rem_q    <= '0;
      silent_q <= (sum_q == '0) && (sq_q == '0);
    end
    if (state_q == slm_pkg::ST_DIVIDE) begin
      rem_q <= alu_ge ? alu_diff[CntW-1:0] : trial[CntW-1:0];
    end
  end

  assign res_o.mean_square = slm_pkg::MEAN_W'(sum_q);
  assign res_o.silent      = silent_q;
  assign res_o.intensity   = lvl_q;

endmodule

>>> hw/rtl/sound_level_meter_unit.sv
// ----------------------------------------------------------------------------
// sound_level_meter_unit: windowed mean-square sound level meter
// Averages squared centred samples per window and classifies the level.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one converter sample per item in tdata; bits above the
//   sample width are ignored. cfg_* writes the window length (index 0) and the
//   four level thresholds (index 1 to 4); other indexes are dropped. write
//   registers only while the block is idle.
//   m_axis carries one result item per completed window.
// sequence:
//   a sample that does not end a window passes through the magnitude, square and
//   accumulate steps. a sample that ends a window adds one divide step per sum
//   bit (35 at default parameters), then up to 4 threshold compares, and then
//   the result is offered to the output register. the shared subtractor
//   serves both the divide and the compares, and s_axis_tready is low while
//   an item is being worked on.
// reset clears the accumulator, the sample count and the output valid flag, and
// returns the configuration registers to their default values. when m_axis stalls, the
// result waits in the output register and the next sample is still taken;
// a second result waits in the engine until the register frees up.
// ----------------------------------------------------------------------------
module sound_level_meter_unit #(
  parameter int unsigned  MaxWindow  = slm_pkg::MAX_WINDOW,
  localparam int unsigned SampleBits = slm_pkg::SAMPLE_BITS,
  localparam int unsigned InTdataW   = ((SampleBits + 7) / 8) * 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [InTdataW-1:0]              s_axis_tdata,   // adc_sample
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // mean_square [22:0], silent [23], intensity [26:24], zero fill
  output logic [slm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [slm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [slm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned ResW = $bits(slm_pkg::res_t);

  slm_pkg::cfg_t cfg_q;
  slm_pkg::res_t res, res_q;
  logic          res_valid, res_ready;
  logic          out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_length      <= slm_pkg::WINDOW_RST;
      cfg_q.level_threshold[0] <= slm_pkg::LEVEL_ONE_RST;
      cfg_q.level_threshold[1] <= slm_pkg::LEVEL_TWO_RST;
      cfg_q.level_threshold[2] <= slm_pkg::LEVEL_THREE_RST;
      cfg_q.level_threshold[3] <= slm_pkg::LEVEL_FOUR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        slm_pkg::REG_WINDOW_LENGTH: cfg_q.window_length <= cfg_data_i[slm_pkg::WIN_W-1:0];
        slm_pkg::REG_LEVEL_ONE:     cfg_q.level_threshold[0] <= cfg_data_i;
        slm_pkg::REG_LEVEL_TWO:     cfg_q.level_threshold[1] <= cfg_data_i;
        slm_pkg::REG_LEVEL_THREE:   cfg_q.level_threshold[2] <= cfg_data_i;
        slm_pkg::REG_LEVEL_FOUR:    cfg_q.level_threshold[3] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  slm_engine #(
    .SampleBits(SampleBits),
    .MaxWindow (MaxWindow)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sample_i   (s_axis_tdata[SampleBits-1:0]),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output register frees as soon as the current item is taken
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = slm_pkg::OUT_TDATA_W'(res_q[ResW-1:0]);

  // the engine is busy and drops s_axis_tready after taking a sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("engine took a sample while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[26:24] <= 3'd4)
    else $error("intensity out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[23] |-> m_axis_tdata[22:0] == '0)
    else $error("silent window with nonzero mean");

endmodule

>>> bench/tb_sound_level_meter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sound_level_meter_unit: self-checking bench for the sound level meter
// Streams converter samples through the block and predicts each window's
// mean square, silent flag and intensity class. Covers the extremes of the
// sample and register ranges, short and long windows and window
// changes mid-window. Also covers bursty input and a stalling result
// consumer, including one long hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_sound_level_meter_unit;
  import slm_pkg::*;

  localparam int unsigned IN_TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned NUM_REGS      = int'(REG_LEVEL_FOUR) + 1;
  localparam int unsigned RESET_CYCLES  = 12;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned TOTAL_ITEMS   = 1250;
  localparam int unsigned PART_WINDOW   = 300;
  localparam int unsigned SAMPLE_MID    = 1 << (SAMPLE_BITS - 1);

  // windowed mean-square predictor and result store
  class level_scoreboard;
    logic [WIN_W-1:0] window_len;
    logic [THR_W-1:0] level_thr [NUM_LEVELS];
    longint unsigned  square_acc;
    int unsigned      samples_in;
    res_t             expected_levels [$];
    int unsigned      mismatches;
    int unsigned      windows_checked;
    int unsigned      silent_windows;
    int unsigned      samples_taken;
    int unsigned      reg_writes;
    int unsigned      dropped_writes;
    int unsigned      level_hits [5];

    function new();
      window_len   = WINDOW_RST;
      level_thr[0] = LEVEL_ONE_RST;
      level_thr[1] = LEVEL_TWO_RST;
      level_thr[2] = LEVEL_THREE_RST;
      level_thr[3] = LEVEL_FOUR_RST;
      square_acc   = 0;
      samples_in   = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %0s", $time, msg);
      mismatches++;
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_WINDOW_LENGTH: window_len = data[WIN_W-1:0];
        REG_LEVEL_ONE, REG_LEVEL_TWO, REG_LEVEL_THREE, REG_LEVEL_FOUR: begin
          level_thr[int'(idx) - 1] = data[THR_W-1:0];
        end
        default: dropped_writes++;
      endcase
    endfunction

    function void take_sample(logic [IN_TDATA_W-1:0] tdata);
      int              centred;
      longint unsigned mag;
      longint unsigned mean;
      int unsigned     span;
      int unsigned     lvl;
      res_t            want;
      samples_taken++;
      // upper tdata bits are dropped before centring
      centred    = int'(tdata[SAMPLE_BITS-1:0]) - int'(SAMPLE_MID);
      mag        = (centred < 0) ? longint'(-centred) : longint'(centred);
      square_acc = square_acc + mag * mag;
      samples_in++;
      span = (window_len == 0) ? 1 : int'(window_len);
      if (span > MAX_WINDOW) span = MAX_WINDOW;
      if (samples_in < span) return;
      // divide by the samples actually taken, which can exceed a shrunk window
      mean = square_acc / samples_in;
      lvl  = 0;
      while (lvl < NUM_LEVELS && !(mean < level_thr[lvl])) lvl++;
      want.mean_square = mean[MEAN_W-1:0];
      want.silent      = (square_acc == 0);
      want.intensity   = lvl[INT_W-1:0];
      expected_levels.push_back(want);
      square_acc = 0;
      samples_in = 0;
    endfunction

    task check_level(logic [OUT_TDATA_W-1:0] tdata);
      res_t got;
      res_t want;
      got = res_t'(tdata[$bits(res_t)-1:0]);
      if (expected_levels.size() == 0) begin
        report($sformatf("result with none pending, tdata %h", tdata));
        return;
      end
      want = expected_levels.pop_front();
      windows_checked++;
      if (want.silent) silent_windows++;
      level_hits[want.intensity]++;
      if (got.mean_square !== want.mean_square)
        report($sformatf("mean_square got %0d want %0d", got.mean_square, want.mean_square));
      if (got.silent !== want.silent)
        report($sformatf("silent got %b want %b", got.silent, want.silent));
      if (got.intensity !== want.intensity)
        report($sformatf("intensity got %0d want %0d", got.intensity, want.intensity));
      if (tdata[OUT_TDATA_W-1:$bits(res_t)] !== '0)
        report($sformatf("fill bits not zero, tdata %h", tdata));
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // adc_sample, upper bits not always zero
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // mean_square [22:0], silent [23], intensity [26:24], zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  level_scoreboard sb;
  int unsigned     burst_left = 0;
  bit              no_gaps = 1'b0;
  bit              long_hold_req = 1'b0;
  int unsigned     input_stalls = 0;

  sound_level_meter_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.take_sample(s_axis_tdata);
      if (s_axis_tvalid && !s_axis_tready) input_stalls++;
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_level(m_axis_tdata);
    end
  end

  // result consumer: stall modes that change every so often, plus one long hold
  initial begin : rx_side
    int unsigned mode;
    int unsigned mode_left;
    mode = 0;
    mode_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 200);
        end
        mode_left--;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((mode_left % 5) < 2);
        endcase
      end
    end
  end

  initial begin : watchdog
    #100_000_000;
    $display("sound_level_meter_unit verification failed");
    $finish;
  end

  // one sample item; bursts of random length with random gaps between, unless no_gaps is set
  task automatic push_sample(input logic [IN_TDATA_W-1:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      if (no_gaps) gap = 0;
      else if ($urandom_range(0, 2) == 0) gap = 0;
      else if ($urandom_range(0, 1) == 0) gap = $urandom_range(1, 6);
      else gap = $urandom_range(7, 60);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop input, wait for every pending window, then let the pipeline drain
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.expected_levels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [IN_TDATA_W-1:0] draw_sample(int unsigned amp_sh, bit quiet);
    logic [IN_TDATA_W-1:0] data;
    int                    centred;
    int unsigned           amp;
    data = IN_TDATA_W'($urandom);
    if (quiet && $urandom_range(0, 7) != 0) begin
      centred = 0;
    end else if ($urandom_range(0, 4) == 0) begin
      centred = int'($urandom_range(0, (1 << SAMPLE_BITS) - 1)) - int'(SAMPLE_MID);
    end else begin
      amp     = 1 << amp_sh;
      centred = int'($urandom_range(0, 2 * amp - 1)) - int'(amp);
    end
    data[SAMPLE_BITS-1:0] = SAMPLE_BITS'(centred + int'(SAMPLE_MID));
    if ($urandom_range(0, 3) != 0) data[IN_TDATA_W-1:SAMPLE_BITS] = '0;
    return data;
  endfunction

  // log-spread threshold so that every class gets hit
  function automatic logic [THR_W-1:0] draw_level();
    logic [THR_W-1:0] val;
    int unsigned      sh;
    sh  = $urandom_range(0, THR_W);
    val = THR_W'($urandom & ((1 << sh) - 1));
    return val;
  endfunction

  task automatic shuffle_settings();
    logic [CFG_DATA_W-1:0] data;
    logic [CFG_IDX_W-1:0]  bad_idx;
    longint unsigned       acc;
    int unsigned           pick;
    int unsigned           span;
    pick = $urandom_range(0, 19);
    if (pick < 2) span = 0;
    else if (pick < 13) span = $urandom_range(1, 8);
    else if (pick < 18) span = $urandom_range(9, 40);
    else span = $urandom_range(41, 200);
    if ($urandom_range(0, 4) != 0) begin
      data = CFG_DATA_W'($urandom);
      data[WIN_W-1:0] = WIN_W'(span);
      if ($urandom_range(0, 2) != 0) data[CFG_DATA_W-1:WIN_W] = '0;
      write_reg(REG_WINDOW_LENGTH, data);
    end
    case ($urandom_range(0, 3))
      0, 1: begin
        acc = 0;
        for (int lvl = 0; lvl < NUM_LEVELS; lvl++) begin
          acc = acc + draw_level();
          if (acc > (1 << THR_W) - 1) acc = (1 << THR_W) - 1;
          write_reg(CFG_IDX_W'(int'(REG_LEVEL_ONE) + lvl), acc[CFG_DATA_W-1:0]);
        end
      end
      2: begin
        for (int lvl = 0; lvl < NUM_LEVELS; lvl++)
          write_reg(CFG_IDX_W'(int'(REG_LEVEL_ONE) + lvl), draw_level());
      end
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0)
      write_reg(CFG_IDX_W'(int'(REG_LEVEL_ONE) + $urandom_range(0, NUM_LEVELS - 1)), '0);
    if ($urandom_range(0, 7) == 0) begin
      bad_idx = CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1));
      write_reg(bad_idx, CFG_DATA_W'($urandom));
    end
  endtask

  initial begin : stim
    int unsigned phase_len;
    int unsigned amp_sh;
    bit          quiet;
    sb = new();
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_WINDOW_LENGTH;
    cfg_data_i    <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // part of a window at reset settings, then closed by a shorter window
    for (int k = 0; k < int'(PART_WINDOW); k++) push_sample(draw_sample(5, 1'b0));
    settle();
    write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(PART_WINDOW));
    push_sample(draw_sample(5, 1'b0));
    settle();

    // single-sample windows against the reset thresholds, class edges
    write_reg(REG_WINDOW_LENGTH, 23'd1);
    push_sample(16'd2048);   // silent
    push_sample(16'd0);      // full negative swing
    push_sample(16'd4095);   // full positive swing
    push_sample(16'd2055);
    push_sample(16'd2056);
    push_sample(16'd2072);
    push_sample(16'd2073);
    push_sample(16'd2126);
    push_sample(16'd2127);
    push_sample(16'd2296);
    push_sample(16'd2297);
    push_sample(16'd2040);
    push_sample(16'hF800);   // upper bits masked, silent
    push_sample(16'h5FFF);
    push_sample(16'hA000);
    settle();

    // window zero, mean equal to a threshold, zero and all-ones thresholds
    write_reg(REG_WINDOW_LENGTH, 23'd0);
    write_reg(REG_LEVEL_ONE, 23'd64);
    write_reg(REG_LEVEL_TWO, 23'd0);
    write_reg(REG_LEVEL_THREE, 23'h7FFFFF);
    write_reg(REG_LEVEL_FOUR, 23'd4194304);
    for (int k = NUM_REGS; k < (1 << CFG_IDX_W); k++) write_reg(CFG_IDX_W'(k), 23'h7FFFFF);
    push_sample(16'd2056);
    push_sample(16'd2055);
    push_sample(16'd0);
    settle();
    write_reg(REG_LEVEL_THREE, 23'd0);
    push_sample(16'd0);
    push_sample(16'd4095);
    settle();

    // window cut short mid-window, written with junk above the window bits
    write_reg(REG_WINDOW_LENGTH, 23'd8);
    for (int k = 0; k < 5; k++) push_sample(draw_sample(11, 1'b0));
    settle();
    write_reg(REG_WINDOW_LENGTH, 23'h7FE003);
    push_sample(draw_sample(11, 1'b0));
    settle();

    // oversized window acts as the longest one: full-scale samples pile up
    // without a result until the window is cut short
    write_reg(REG_WINDOW_LENGTH, 23'h001FFF);
    for (int k = 0; k < int'(PART_WINDOW); k++) push_sample(16'd0);
    settle();
    write_reg(REG_WINDOW_LENGTH, 23'd1);
    push_sample(16'd0);
    settle();

    // back-pressure: results pile up until the input stalls
    long_hold_req = 1'b1;
    no_gaps = 1'b1;
    for (int k = 0; k < 30; k++) push_sample(draw_sample($urandom_range(0, 11), 1'b0));
    no_gaps = 1'b0;

    while (sb.samples_taken < TOTAL_ITEMS) begin
      settle();
      shuffle_settings();
      quiet     = ($urandom_range(0, 6) == 0);
      amp_sh    = $urandom_range(0, SAMPLE_BITS - 1);
      no_gaps   = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(10, 80);
      repeat (phase_len) push_sample(draw_sample(amp_sh, quiet));
    end
    settle();

    $display("run: %0d samples, %0d windows checked (%0d silent), %0d input stall cycles",
             sb.samples_taken, sb.windows_checked, sb.silent_windows, input_stalls);
    $display("run: intensity 0..4 seen %0d/%0d/%0d/%0d/%0d, %0d reg writes (%0d dropped)",
             sb.level_hits[0], sb.level_hits[1], sb.level_hits[2], sb.level_hits[3],
             sb.level_hits[4], sb.reg_writes, sb.dropped_writes);
    if (sb.mismatches == 0) begin
      $display("sound_level_meter_unit verification clean");
    end else begin
      $display("sound_level_meter_unit verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/slm_pkg.sv
hw/rtl/slm_sub.sv
hw/rtl/slm_engine.sv
hw/rtl/sound_level_meter_unit.sv
bench/tb_sound_level_meter_unit.sv
